### src/esc2u_pkg.sv
`default_nettype none
package esc2u_pkg;

   localparam logic [7:0] ESC_CHAR = 8'h5C;

   // Held window: a leading backslash and up to one byte after it
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] pend1;
      logic [7:0] pend0;
   } esc2u_state_type;

   // Bytes caused by one input word, sent from index 0 upward
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
   } esc2u_result_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] cp;
   } esc2u_lookup_type;

   // Map the two bytes after a backslash to a codepoint
   function automatic esc2u_lookup_type esc_lookup(input logic [7:0] a, input logic [7:0] b);
      esc2u_lookup_type r;
      r.hit = 1'b1;
      case ({a, b})
         16'h2241: r.cp = 16'h00C4;
         16'h2245: r.cp = 16'h00CB;
         16'h2249: r.cp = 16'h00CF;
         16'h224F: r.cp = 16'h00D6;
         16'h2255: r.cp = 16'h00DC;
         16'h2261: r.cp = 16'h00E4;
         16'h2265: r.cp = 16'h00EB;
         16'h2269: r.cp = 16'h00EF;
         16'h226F: r.cp = 16'h00F6;
         16'h2275: r.cp = 16'h00FC;
         16'h2741: r.cp = 16'h00C1;
         16'h2745: r.cp = 16'h00C9;
         16'h2749: r.cp = 16'h00CD;
         16'h274F: r.cp = 16'h00D3;
         16'h2755: r.cp = 16'h00DA;
         16'h2761: r.cp = 16'h00E1;
         16'h2765: r.cp = 16'h00E9;
         16'h2769: r.cp = 16'h00ED;
         16'h276F: r.cp = 16'h00F3;
         16'h2775: r.cp = 16'h00FA;
         16'h4145: r.cp = 16'h00C6;
         16'h484F: r.cp = 16'h0150;
         16'h4855: r.cp = 16'h0170;
         16'h486F: r.cp = 16'h0151;
         16'h4875: r.cp = 16'h0171;
         16'h4F45: r.cp = 16'h0152;
         16'h5E41: r.cp = 16'h00C2;
         16'h5E45: r.cp = 16'h00CA;
         16'h5E49: r.cp = 16'h00CE;
         16'h5E4F: r.cp = 16'h00D4;
         16'h5E55: r.cp = 16'h00DB;
         16'h5E61: r.cp = 16'h00E2;
         16'h5E65: r.cp = 16'h00EA;
         16'h5E69: r.cp = 16'h00EE;
         16'h5E6F: r.cp = 16'h00F4;
         16'h5E75: r.cp = 16'h00FB;
         16'h603F: r.cp = 16'h00BF;
         16'h6041: r.cp = 16'h00C0;
         16'h6045: r.cp = 16'h00C8;
         16'h6049: r.cp = 16'h00CC;
         16'h604F: r.cp = 16'h00D2;
         16'h6055: r.cp = 16'h00D9;
         16'h6061: r.cp = 16'h00E0;
         16'h6065: r.cp = 16'h00E8;
         16'h6069: r.cp = 16'h00EC;
         16'h606F: r.cp = 16'h00F2;
         16'h6075: r.cp = 16'h00F9;
         16'h6165: r.cp = 16'h00E6;
         16'h6343: r.cp = 16'h00C7;
         16'h6363: r.cp = 16'h00E7;
         16'h6372: r.cp = 16'h000D;
         16'h6575: r.cp = 16'h0080;
         16'h676C: r.cp = 16'h00AB;
         16'h6772: r.cp = 16'h00BB;
         16'h6874: r.cp = 16'h0009;
         16'h6C66: r.cp = 16'h000A;
         16'h6F4F: r.cp = 16'h00D8;
         16'h6F65: r.cp = 16'h0153;
         16'h6F6F: r.cp = 16'h00F8;
         16'h706E: r.cp = 16'h00A3;
         16'h7241: r.cp = 16'h00C5;
         16'h7261: r.cp = 16'h00E5;
         16'h7271: r.cp = 16'h2019;
         16'h7373: r.cp = 16'h00DF;
         16'h746D: r.cp = 16'h0099;
         16'h7E41: r.cp = 16'h00C3;
         16'h7E4E: r.cp = 16'h00D1;
         16'h7E4F: r.cp = 16'h00D5;
         16'h7E61: r.cp = 16'h00E3;
         16'h7E6E: r.cp = 16'h00F1;
         16'h7E6F: r.cp = 16'h00F5;
         default: begin
            r.hit = 1'b0;
            r.cp  = 16'h0000;
         end
      endcase
      return r;
   endfunction

   // UTF-8 encode a codepoint below 0x10000
   function automatic esc2u_result_type utf8_encode(input logic [15:0] cp);
      esc2u_result_type r;
      r.bytes = '0;
      if (cp < 16'h0080) begin
         r.count    = 2'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp < 16'h0800) begin
         r.count    = 2'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else begin
         r.count    = 2'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### src/esc2u_step.sv
`default_nettype none
module esc2u_step (
   input  wire esc2u_pkg::esc2u_state_type  state,
   input  wire logic [7:0]                  in_byte,
   input  wire logic                        in_last,
   output esc2u_pkg::esc2u_result_type      result,
   output esc2u_pkg::esc2u_state_type       state_in
);
   import esc2u_pkg::*;

   esc2u_lookup_type lk;
   logic             in_esc;
   logic             p1_esc;

   assign lk     = esc_lookup(state.pend1, in_byte);
   assign in_esc = (in_byte == ESC_CHAR);
   assign p1_esc = (state.pend1 == ESC_CHAR);

   // Resolve the window of held bytes plus the new word
   always_comb begin
      result   = '0;
      state_in = '0;
      case (state.count)
         2'd0: begin
            if (in_esc && !in_last) begin
               state_in.count = 2'd1;
               state_in.pend0 = in_byte;
            end else begin
               result.count    = 2'd1;
               result.bytes[0] = in_byte;
            end
         end
         2'd1: begin
            if (in_last) begin
               result.count    = 2'd2;
               result.bytes[0] = state.pend0;
               result.bytes[1] = in_byte;
            end else begin
               state_in.count = 2'd2;
               state_in.pend0 = state.pend0;
               state_in.pend1 = in_byte;
            end
         end
         default: begin
            // full window: decode an escape or release the backslash
            if (lk.hit) begin
               result = utf8_encode(lk.cp);
            end else begin
               result.bytes[0] = state.pend0;
               if (!p1_esc) begin
                  result.bytes[1] = state.pend1;
                  if (!in_esc || in_last) begin
                     result.count    = 2'd3;
                     result.bytes[2] = in_byte;
                  end else begin
                     result.count   = 2'd2;
                     state_in.count = 2'd1;
                     state_in.pend0 = in_byte;
                  end
               end else if (in_last) begin
                  result.count    = 2'd3;
                  result.bytes[1] = state.pend1;
                  result.bytes[2] = in_byte;
               end else begin
                  result.count   = 2'd1;
                  state_in.count = 2'd2;
                  state_in.pend0 = state.pend1;
                  state_in.pend1 = in_byte;
               end
            end
         end
      endcase
   end

endmodule
`default_nettype wire

### src/escape_sequence_to_utf8.sv
`default_nettype none
// Escape-sequence to UTF-8 expander. Each accepted word is resolved in the
// cycle it is taken, against a window of up to two held bytes, into 0 to 3
// output words that wait in a three-entry result register and leave one per
// cycle while rsp_stall is low. A word that causes at most one output word is
// taken every cycle while the output side keeps up; after a word that causes
// two or three output words, the input stalls while the result register
// drains. A backslash with fewer than two bytes behind it produces nothing
// until the window fills or the message ends.
module escape_sequence_to_utf8 (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_message_last
);
   import esc2u_pkg::*;

   esc2u_state_type  state_ff, state_in, state_step;
   esc2u_result_type result;
   logic [2:0][7:0]  ob_ff, ob_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             msg_ff, msg_in;
   logic             accept;
   logic             pop;

   esc2u_step u_step (
      .state    (state_ff),
      .in_byte  (req_in_byte),
      .in_last  (req_in_last),
      .result   (result),
      .state_in (state_step)
   );

   // Take a word once the result register empties this cycle
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !rsp_stall));
   assign accept    = req_valid && !req_stall;

   // Advance the window only on an accepted word
   assign state_in = accept ? state_step : state_ff;

   // Load a fresh result or shift out the head word
   always_comb begin
      ob_in  = ob_ff;
      cnt_in = cnt_ff;
      msg_in = msg_ff;
      if (accept) begin
         ob_in  = result.bytes;
         cnt_in = result.count;
         msg_in = req_in_last;
      end else if (pop) begin
         ob_in[0] = ob_ff[1];
         ob_in[1] = ob_ff[2];
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ob_ff  <= ob_in;
      msg_ff <= msg_in;
   end

   // Drive the head word and its end flags
   assign rsp_valid        = (cnt_ff != 2'd0);
   assign rsp_out_byte     = ob_ff[0];
   assign rsp_run_last     = (cnt_ff == 2'd1);
   assign rsp_message_last = (cnt_ff == 2'd1) && msg_ff;

endmodule
`default_nettype wire

### tb/escape_sequence_to_utf8_checker.sv
`timescale 1ns / 100ps
module escape_sequence_to_utf8_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_run_last,
   input  logic       rsp_message_last,
   output int         fail_count = 0,
   output int         words_pending = 0
);
   import esc2u_pkg::*;

   localparam logic [7:0] GRAVE = 8'h60;

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       msg_end;
   } utf8_word_type;

   // Held window: up to two bytes, a backslash first
   logic [7:0]    held_bytes [2];
   int            held_count;
   utf8_word_type utf8_words [$];

   // Resolve one input word against the window and queue the UTF-8 words it causes
   task automatic expand_word(input logic [7:0] in_byte, input logic in_last);
      logic [7:0]    win [3];
      logic [7:0]    outb [3];
      logic [15:0]   cp;
      logic          hit;
      logic          waiting;
      int            n;
      int            k;
      int            s;
      utf8_word_type w;

      n = (held_count > 2) ? 2 : held_count;
      for (int i = 0; i < n; i++) win[i] = held_bytes[i];
      win[n] = in_byte;
      n++;
      k = 0;
      s = 0;
      waiting = 1'b0;
      cp = '0;

      while (s < n && !waiting) begin
         if (win[s] != ESC_CHAR) begin
            outb[k] = win[s];
            k++;
            s++;
         end else if (n - s < 3) begin
            waiting = 1'b1;
         end else begin
            hit = 1'b1;
            case ({win[s+1], win[s+2]})
               "\"A": cp = 16'h00C4;
               "\"E": cp = 16'h00CB;
               "\"I": cp = 16'h00CF;
               "\"O": cp = 16'h00D6;
               "\"U": cp = 16'h00DC;
               "\"a": cp = 16'h00E4;
               "\"e": cp = 16'h00EB;
               "\"i": cp = 16'h00EF;
               "\"o": cp = 16'h00F6;
               "\"u": cp = 16'h00FC;
               "'A": cp = 16'h00C1;
               "'E": cp = 16'h00C9;
               "'I": cp = 16'h00CD;
               "'O": cp = 16'h00D3;
               "'U": cp = 16'h00DA;
               "'a": cp = 16'h00E1;
               "'e": cp = 16'h00E9;
               "'i": cp = 16'h00ED;
               "'o": cp = 16'h00F3;
               "'u": cp = 16'h00FA;
               "AE": cp = 16'h00C6;
               "HO": cp = 16'h0150;
               "HU": cp = 16'h0170;
               "Ho": cp = 16'h0151;
               "Hu": cp = 16'h0171;
               "OE": cp = 16'h0152;
               "^A": cp = 16'h00C2;
               "^E": cp = 16'h00CA;
               "^I": cp = 16'h00CE;
               "^O": cp = 16'h00D4;
               "^U": cp = 16'h00DB;
               "^a": cp = 16'h00E2;
               "^e": cp = 16'h00EA;
               "^i": cp = 16'h00EE;
               "^o": cp = 16'h00F4;
               "^u": cp = 16'h00FB;
               {GRAVE, "?"}: cp = 16'h00BF;
               {GRAVE, "A"}: cp = 16'h00C0;
               {GRAVE, "E"}: cp = 16'h00C8;
               {GRAVE, "I"}: cp = 16'h00CC;
               {GRAVE, "O"}: cp = 16'h00D2;
               {GRAVE, "U"}: cp = 16'h00D9;
               {GRAVE, "a"}: cp = 16'h00E0;
               {GRAVE, "e"}: cp = 16'h00E8;
               {GRAVE, "i"}: cp = 16'h00EC;
               {GRAVE, "o"}: cp = 16'h00F2;
               {GRAVE, "u"}: cp = 16'h00F9;
               "ae": cp = 16'h00E6;
               "cC": cp = 16'h00C7;
               "cc": cp = 16'h00E7;
               "cr": cp = 16'h000D;
               "eu": cp = 16'h0080;
               "gl": cp = 16'h00AB;
               "gr": cp = 16'h00BB;
               "ht": cp = 16'h0009;
               "lf": cp = 16'h000A;
               "oO": cp = 16'h00D8;
               "oe": cp = 16'h0153;
               "oo": cp = 16'h00F8;
               "pn": cp = 16'h00A3;
               "rA": cp = 16'h00C5;
               "ra": cp = 16'h00E5;
               "rq": cp = 16'h2019;
               "ss": cp = 16'h00DF;
               "tm": cp = 16'h0099;
               "~A": cp = 16'h00C3;
               "~N": cp = 16'h00D1;
               "~O": cp = 16'h00D5;
               "~a": cp = 16'h00E3;
               "~n": cp = 16'h00F1;
               "~o": cp = 16'h00F5;
               default: hit = 1'b0;
            endcase

            if (k == 0 && hit) begin
               // Encode the codepoint, dropping all three window bytes
               if (cp < 16'h0080) begin
                  outb[0] = cp[7:0];
                  k = 1;
               end else if (cp < 16'h0800) begin
                  outb[0] = {3'b110, cp[10:6]};
                  outb[1] = {2'b10, cp[5:0]};
                  k = 2;
               end else begin
                  outb[0] = {4'b1110, cp[15:12]};
                  outb[1] = {2'b10, cp[11:6]};
                  outb[2] = {2'b10, cp[5:0]};
                  k = 3;
               end
               s += 3;
            end else begin
               outb[k] = win[s];
               k++;
               s++;
            end
         end
      end

      // Flush the window at message end, else hold what is left
      held_bytes[0] = '0;
      held_bytes[1] = '0;
      if (in_last) begin
         while (s < n && k < 3) begin
            outb[k] = win[s];
            k++;
            s++;
         end
         held_count = 0;
      end else begin
         for (int i = 0; i < n - s && i < 2; i++) held_bytes[i] = win[s+i];
         held_count = (n - s > 2) ? 2 : n - s;
      end

      for (int i = 0; i < k; i++) begin
         w.data    = outb[i];
         w.run_end = (i == k - 1);
         w.msg_end = (i == k - 1) && in_last;
         utf8_words = {utf8_words, w};
      end
   endtask

   // Predict on each accepted input word, compare each accepted output word
   always @(posedge clock) begin
      utf8_word_type w;
      if (reset) begin
         held_bytes[0] = '0;
         held_bytes[1] = '0;
         held_count = 0;
         utf8_words.delete();
      end else begin
         if (req_valid && !req_stall) expand_word(req_in_byte, req_in_last);
         if (rsp_valid && !rsp_stall) begin
            if (utf8_words.size() == 0) begin
               $error("unexpected output word: out_byte %h run_last %b message_last %b",
                      rsp_out_byte, rsp_run_last, rsp_message_last);
               fail_count++;
            end else begin
               w = utf8_words.pop_front();
               if (rsp_out_byte !== w.data) begin
                  $error("out_byte: expected %h, got %h", w.data, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_run_last !== w.run_end) begin
                  $error("run_last: expected %b, got %b", w.run_end, rsp_run_last);
                  fail_count++;
               end
               if (rsp_message_last !== w.msg_end) begin
                  $error("message_last: expected %b, got %b", w.msg_end, rsp_message_last);
                  fail_count++;
               end
            end
         end
      end
      words_pending = utf8_words.size();
   end

endmodule

### tb/escape_sequence_to_utf8_tb.sv
`timescale 1ns / 100ps
module escape_sequence_to_utf8_tb;
   import esc2u_pkg::*;

   localparam int         RANDOM_WORDS = 310;
   localparam logic [7:0] GRAVE        = 8'h60;

   // All 71 escape pairs, two characters each
   localparam logic [8*142-1:0] ESCAPE_PAIRS = {
      "\"A\"E\"I\"O\"U\"a\"e\"i\"o\"u'A'E'I'O'U'a'e'i'o'u",
      "AEHOHUHoHuOE^A^E^I^O^U^a^e^i^o^u",
      GRAVE, "?", GRAVE, "A", GRAVE, "E", GRAVE, "I", GRAVE, "O", GRAVE, "U",
      GRAVE, "a", GRAVE, "e", GRAVE, "i", GRAVE, "o", GRAVE, "u",
      "aecCcccreuglgrhtlfoOoeoopnrArarqsstm~A~N~O~a~n~o"
   };

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte      = 8'h00;
   logic       req_in_last      = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_message_last;
   int         fail_count;
   int         words_pending;

   int words_offered = 0;
   int burst_left    = 4;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   escape_sequence_to_utf8 dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_message_last (rsp_message_last)
   );

   escape_sequence_to_utf8_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_message_last (rsp_message_last),
      .fail_count       (fail_count),
      .words_pending    (words_pending)
   );

   // Offer one word from a falling edge, hold it until taken, then maybe pause
   task automatic offer_word(input logic [7:0] in_byte, input logic in_last);
      req_valid   <= 1'b1;
      req_in_byte <= in_byte;
      req_in_last <= in_last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_offered++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic send_text(input string txt);
      for (int i = 0; i < txt.len(); i++) offer_word(txt[i], i == txt.len() - 1);
   endtask

   // Receiver: switch among random stall modes, with one long hold-off
   initial begin : receiver
      int             cyc;
      int             hold_left;
      stall_mode_type mode;
      cyc = 0;
      hold_left = 0;
      mode = STALL_NONE;
      forever begin
         @(negedge clock);
         if (!reset) cyc++;
         if (cyc == 300) hold_left = 90;
         if (cyc % 50 == 0) mode = stall_mode_type'($urandom_range(0, 3));
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= cyc[0];
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [7:0] text_q [$];
      logic [7:0] first;
      int         pick;
      int         pair;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Byte extremes, then one message per kind of window behavior
      offer_word(8'h00, 1'b0);
      offer_word(8'hFF, 1'b1);
      send_text("\\rqA");       // three-byte codepoint, then a literal
      send_text("\\\"A\\");     // two-byte codepoint, backslash flushed at end
      send_text("\\\\'e");      // doubled backslash: first literal, second escapes
      send_text("\\zz");        // no escape: backslash and both bytes pass
      send_text("\\eu\\tm\\");  // C1 range codepoints, trailing backslash
      send_text("\\");          // lone backslash as the whole message
      send_text("\\ht");        // one-byte codepoint ends the message

      // Random messages: mostly escapes, with noise and cut-off sequences
      while (words_offered < RANDOM_WORDS) begin
         text_q.delete();
         repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 99);
            pair = $urandom_range(0, 70);
            first = ESCAPE_PAIRS[8*(141 - 2*pair) +: 8];
            if (pick < 55) begin
               text_q = {text_q, ESC_CHAR, first, ESCAPE_PAIRS[8*(140 - 2*pair) +: 8]};
            end else if (pick < 65) begin
               text_q = {text_q, ESC_CHAR, first, 8'($urandom_range(0, 255))};
            end else if (pick < 80) begin
               text_q = {text_q, 8'($urandom_range(0, 255))};
            end else if (pick < 90) begin
               text_q = {text_q, ESC_CHAR};
            end else begin
               text_q = {text_q, 8'($urandom_range(8'h20, 8'h7E))};
            end
         end
         if (text_q.size() > 1 && $urandom_range(0, 5) == 0) void'(text_q.pop_back());
         for (int i = 0; i < text_q.size(); i++)
            offer_word(text_q[i], i == text_q.size() - 1);
      end
      req_valid <= 1'b0;

      // Drain, then wait for stray words
      while (words_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("escape_sequence_to_utf8: match");
      else
         $display("escape_sequence_to_utf8: mismatch");
      $finish;
   end

   initial begin : watchdog
      #2400000;
      $display("escape_sequence_to_utf8: mismatch");
      $finish;
   end

endmodule
